// ----- src/u8sb_pkg.sv -----
// ----------------------------------------------------------------------------
// u8sb_pkg
// Shared types and constants for the UTF-8 to single-byte transcoder.
// ----------------------------------------------------------------------------
package u8sb_pkg;

	localparam int unsigned ACC_W = 21;

	localparam logic [7:0] SUBST_RESET = 8'h3F;

	typedef struct packed {
		logic [ACC_W-1:0] code_accum;
		logic [1:0]       bytes_pending;
		logic             error_seen;
	} dec_state_t;

	typedef struct packed {
		logic       present;
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       bad_utf8;
		logic       stream_done;
	} dec_result_t;

endpackage

// ----- src/u8sb_decode.sv -----
// ----------------------------------------------------------------------------
// u8sb_decode
// Next-state and result logic for one UTF-8 byte: sequence gathering, error
// tracking and the code point to single-byte mapping.
// ----------------------------------------------------------------------------
module u8sb_decode import u8sb_pkg::*; (
	input  dec_state_t  cur,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	input  logic [7:0]  substitute_byte,
	output dec_state_t  nxt,
	output dec_result_t res
);

	function automatic logic [7:0] map_code(input logic [ACC_W-1:0] cp,
		input logic [7:0] subst);
		logic [7:0] m;
		begin
			if (cp <= ACC_W'(12'h0FF)) begin
				m = cp[7:0];
			end else if (cp == ACC_W'(12'h401)) begin
				m = 8'hA8;
			end else if (cp == ACC_W'(12'h451)) begin
				m = 8'hB8;
			end else if (cp >= ACC_W'(12'h410) && cp <= ACC_W'(12'h44F)) begin
				m = cp[7:0] + 8'hB0;
			end else begin
				m = subst;
			end
			return m;
		end
	endfunction

	logic             emit;
	logic [7:0]       ch;
	logic [ACC_W-1:0] acc;
	logic [1:0]       pend;
	logic             err;

	always_comb begin
		emit = 1'b0;
		ch   = 8'h00;
		acc  = cur.code_accum;
		pend = cur.bytes_pending;
		err  = cur.error_seen;
		if (!cur.error_seen) begin
			if (cur.bytes_pending == 2'd0) begin
				if (!in_byte[7]) begin
					ch   = in_byte;
					emit = 1'b1;
				end else if ((in_byte & 8'hE0) == 8'hC0) begin
					acc  = ACC_W'(in_byte[4:0]);
					pend = 2'd1;
				end else if ((in_byte & 8'hF0) == 8'hE0) begin
					acc  = ACC_W'(in_byte[3:0]);
					pend = 2'd2;
				end else if ((in_byte & 8'hF8) == 8'hF0) begin
					acc  = ACC_W'(in_byte[2:0]);
					pend = 2'd3;
				end else begin
					err = 1'b1;
				end
			end else if ((in_byte & 8'hC0) == 8'h80) begin
				acc  = {cur.code_accum[ACC_W-7:0], in_byte[5:0]};
				pend = cur.bytes_pending - 2'd1;
				if (pend == 2'd0) begin
					ch   = map_code(acc, substitute_byte);
					emit = 1'b1;
				end
			end else begin
				err = 1'b1;
			end
			if (last_byte && pend != 2'd0) begin
				err = 1'b1;
			end
			if (err) begin
				acc  = '0;
				pend = 2'd0;
			end
		end

		res.present     = emit || last_byte;
		res.out_byte    = emit ? ch : 8'h00;
		res.byte_valid  = emit;
		res.bad_utf8    = err;
		res.stream_done = last_byte;

		if (last_byte) begin
			nxt = '0;
		end else begin
			nxt.code_accum    = acc;
			nxt.bytes_pending = pend;
			nxt.error_seen    = err;
		end
	end

endmodule

// ----- src/utf8_to_single_byte_transcoder.sv -----
// ----------------------------------------------------------------------------
// utf8_to_single_byte_transcoder
// Converts a UTF-8 byte stream into single-byte Cyrillic-style characters.
// ----------------------------------------------------------------------------
// Input bytes arrive on the s_axis channel, one byte per transfer, with tlast
// on the final byte of a text. Each completed code point yields one transfer
// on m_axis. A byte that completes nothing yields no transfer unless it is the
// final byte, which always yields exactly one transfer with tlast set.
// tuser reports whether tdata carries a character and whether invalid or
// truncated UTF-8 was seen in the current text; after an error, bytes are
// dropped until the final byte.
// The cfg channel writes the substitution byte and is always ready; the user
// must write it only while the block is idle; the block does not enforce this.
// An input transfer passes through the input register and then the result
// register. Throughput is one byte per cycle while the receiver accepts, set
// by the single state update per byte in the decoder.
// When the receiver stalls, the result register holds and the input register
// fills, after which s_axis_tready drops. Reset clears all stream state, the valid
// flags of both registers, and sets the substitution byte to 0x3F.
// ----------------------------------------------------------------------------
module utf8_to_single_byte_transcoder import u8sb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,       // [7:0] substitute_byte
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] bad_utf8
	output logic       m_axis_tlast
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [7:0]  subst_q;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [1:0]  out_user_q;
	logic        out_last_q;
	logic        advance;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	u8sb_decode u_decode (
		.cur             (state_q),
		.in_byte         (byte_s1),
		.last_byte       (last_s1),
		.substitute_byte (subst_q),
		.nxt             (state_nxt),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subst_q <= SUBST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			subst_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.present;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.present) begin
			out_byte_q <= res.out_byte;
			out_user_q <= {res.bad_utf8, res.byte_valid};
			out_last_q <= res.stream_done;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_char_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
		else $error("character transfer flagged as bad UTF-8");

	a_empty_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 8'h00)
		else $error("transfer without character that does not close the stream");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q == '0)
		else $error("stream state not cleared after final byte");
`endif

endmodule
